FILE: design/wdbp_pkg.sv
// Package for the wiggle data block parser.
// Shared widths, record kinds, register indexes and the window status type.
// No dependencies.
`default_nettype none
package wdbp_pkg;

	localparam int WORD_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 16;
	localparam int POS_W   = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [POS_W-1:0] HDR_KIND_POS = POS_W'(20);
	localparam logic [POS_W-1:0] HDR_LAST_POS = POS_W'(23);
	localparam logic [POS_W-1:0] BED_LAST_POS = POS_W'(11);
	localparam logic [POS_W-1:0] VAR_LAST_POS = POS_W'(7);
	localparam logic [POS_W-1:0] FIX_LAST_POS = POS_W'(3);

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_BYTE_SWAPPED = 2'd0;
	localparam cfg_idx_t CFG_QUERY_BEGIN  = 2'd1;
	localparam cfg_idx_t CFG_QUERY_END    = 2'd2;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_BED  = 2'd1,
		KIND_VAR  = 2'd2,
		KIND_FIX  = 2'd3
	} kind_t;

	typedef struct packed {
		logic missed;
		logic hit;
	} win_t;

endpackage
`default_nettype wire

FILE: design/wdbp_if.sv
// Stream interfaces of the wiggle data block parser: byte, row and register write channels.
// Depends on wdbp_pkg.
`default_nettype none
interface wdbp_byte_if import wdbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              block_last;
	modport source (output valid, data_byte, block_last, input ready);
	modport sink (input valid, data_byte, block_last, output ready);
endinterface

interface wdbp_row_if import wdbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] row_start;
	logic [WORD_W-1:0] row_end;
	logic [WORD_W-1:0] row_value_bits;
	logic [WORD_W-1:0] chromosome;
	logic              bad_type;
	logic              final_row;
	modport source (output valid, row_start, row_end, row_value_bits, chromosome,
		bad_type, final_row, input ready);
	modport sink (input valid, row_start, row_end, row_value_bits, chromosome,
		bad_type, final_row, output ready);
endinterface

interface wdbp_cfg_if import wdbp_pkg::*; ();
	logic              valid;
	logic              ready;
	cfg_idx_t          addr;
	logic [WORD_W-1:0] wdata;
	modport source (output valid, addr, wdata, input ready);
	modport sink (input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

FILE: design/wdbp_window.sv
// Query window test: resolves the window bounds and checks segment and row overlap.
// Depends on wdbp_pkg.
`default_nettype none
module wdbp_window import wdbp_pkg::*; (
	input  wire logic [WORD_W-1:0] query_begin,
	input  wire logic [WORD_W-1:0] query_end,
	input  wire logic [WORD_W-1:0] seg_start,
	input  wire logic [WORD_W-1:0] seg_end,
	input  wire logic [WORD_W-1:0] row_start,
	input  wire logic [WORD_W-1:0] row_end,
	output win_t                   status
);
	logic signed [WORD_W-1:0] lo;
	logic signed [WORD_W-1:0] hi;

	always_comb begin
		lo = query_begin[WORD_W-1] ? $signed(seg_start) : $signed(query_begin);
		hi = query_end[WORD_W-1] ? $signed(seg_end) : $signed(query_end);
		status.missed = (hi < $signed(seg_start)) || (lo > $signed(seg_end)) || (hi < lo);
		status.hit = ($signed(row_start) <= hi) && ($signed(row_end) >= lo);
	end
endmodule
`default_nettype wire

FILE: design/wig_data_block_parser.sv
// Top level of the wiggle data block parser.
// Depends on wdbp_pkg, wdbp_if and wdbp_window.
//
// Takes one byte of a decompressed wiggle data block per cycle: a 24-byte header, then bed,
// variable-step or fixed-step records. Each record that overlaps the query window gives one
// row in the cycle after its last byte; an unknown header type gives one row with bad_type set.
// The block accepts one byte every cycle; a single output register holds the pending row, so
// input stalls only while a row waits and the row sink is not ready. Fixed-step positions come
// from running start and end accumulators, so no multiplier stands in the byte path.
// Register writes are taken at any time and are meant to happen while no block is in flight.
`default_nettype none
module wig_data_block_parser import wdbp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wdbp_byte_if.sink  bytes,
	wdbp_row_if.source rows,
	wdbp_cfg_if.sink   cfg
);
	logic               swap_q;
	logic [WORD_W-1:0]  qbegin_q;
	logic [WORD_W-1:0]  qend_q;

	logic [POS_W-1:0]   pos_q;
	logic               in_header_q;
	logic [WORD_W-1:0]  asm_q;
	logic [WORD_W-1:0]  chrom_q;
	logic [WORD_W-1:0]  seg_start_q;
	logic [WORD_W-1:0]  seg_end_q;
	logic [WORD_W-1:0]  step_q;
	logic [WORD_W-1:0]  span_q;
	kind_t              kind_q;
	logic [COUNT_W-1:0] total_q;
	logic [COUNT_W-1:0] index_q;
	logic [WORD_W-1:0]  held_start_q;
	logic [WORD_W-1:0]  held_end_q;
	logic               missed_q;
	logic [WORD_W-1:0]  fix_start_q;
	logic [WORD_W-1:0]  fix_end_q;

	logic               out_valid_q;
	logic [WORD_W-1:0]  out_start_q;
	logic [WORD_W-1:0]  out_end_q;
	logic [WORD_W-1:0]  out_value_q;
	logic [WORD_W-1:0]  out_chrom_q;
	logic               out_bad_q;
	logic               out_final_q;

	logic               accept;
	logic [1:0]         lane;
	logic [WORD_W-1:0]  word_base;
	logic [WORD_W-1:0]  word;
	kind_t              kind_dec;
	logic               active_rec;
	logic               hdr_done;
	logic               row_done;
	logic               cap_start;
	logic               cap_end;
	logic [WORD_W-1:0]  rs;
	logic [WORD_W-1:0]  re;
	logic [COUNT_W:0]   index_inc;
	win_t               win;

	assign bytes.ready = !out_valid_q || rows.ready;
	assign accept      = bytes.valid && bytes.ready;
	assign cfg.ready   = 1'b1;

	always_comb begin
		lane = pos_q[1:0];
		word_base = (lane == 2'd0) ? '0 : asm_q;
		if (swap_q) begin
			word = {word_base[WORD_W-BYTE_W-1:0], bytes.data_byte};
		end else begin
			word = word_base | ({{(WORD_W-BYTE_W){1'b0}}, bytes.data_byte} << {lane, 3'b000});
		end
		if (bytes.data_byte[BYTE_W-1:2] == '0 && bytes.data_byte[1:0] != 2'd0) begin
			kind_dec = kind_t'(bytes.data_byte[1:0]);
		end else begin
			kind_dec = KIND_NONE;
		end
		active_rec = !in_header_q && (kind_q != KIND_NONE) && (index_q < total_q);
		hdr_done = in_header_q && (pos_q >= HDR_LAST_POS);
		unique case (kind_q)
			KIND_BED: begin
				row_done = (pos_q == BED_LAST_POS);
				rs = held_start_q;
				re = held_end_q;
			end
			KIND_VAR: begin
				row_done = (pos_q == VAR_LAST_POS);
				rs = held_start_q;
				re = held_end_q;
			end
			KIND_FIX: begin
				row_done = (pos_q == FIX_LAST_POS);
				rs = fix_start_q;
				re = fix_end_q;
			end
			KIND_NONE: begin
				row_done = 1'b0;
				rs = '0;
				re = '0;
			end
		endcase
		row_done  = row_done && active_rec;
		cap_start = active_rec && !row_done && (lane == 2'd3) && (pos_q[POS_W-1:2] == '0);
		cap_end   = active_rec && !row_done && (lane == 2'd3) && (pos_q[POS_W-1:2] != '0);
		index_inc = {1'b0, index_q} + 1'b1;
	end

	wdbp_window u_window (
		.query_begin (qbegin_q),
		.query_end   (qend_q),
		.seg_start   (seg_start_q),
		.seg_end     (seg_end_q),
		.row_start   (rs),
		.row_end     (re),
		.status      (win)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q   <= 1'b0;
			qbegin_q <= '1;
			qend_q   <= '1;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				CFG_BYTE_SWAPPED: swap_q <= cfg.wdata[0];
				CFG_QUERY_BEGIN:  qbegin_q <= cfg.wdata;
				CFG_QUERY_END:    qend_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			in_header_q  <= 1'b1;
			asm_q        <= '0;
			chrom_q      <= '0;
			seg_start_q  <= '0;
			seg_end_q    <= '0;
			step_q       <= '0;
			span_q       <= '0;
			kind_q       <= KIND_NONE;
			total_q      <= '0;
			index_q      <= '0;
			held_start_q <= '0;
			held_end_q   <= '0;
			missed_q     <= 1'b0;
			fix_start_q  <= '0;
			fix_end_q    <= '0;
		end else if (accept) begin
			if (in_header_q || active_rec) begin
				asm_q <= word;
			end
			if (in_header_q) begin
				if (pos_q == HDR_KIND_POS) begin
					kind_q <= kind_dec;
				end
				if (lane == 2'd3) begin
					unique case (pos_q[POS_W-1:2])
						3'd0: chrom_q <= word;
						3'd1: seg_start_q <= word;
						3'd2: seg_end_q <= word;
						3'd3: step_q <= word;
						3'd4: span_q <= word;
						default: total_q <= swap_q ? word[COUNT_W-1:0] : word[WORD_W-1:COUNT_W];
					endcase
				end
				if (hdr_done) begin
					in_header_q <= 1'b0;
					pos_q       <= '0;
					index_q     <= '0;
					missed_q    <= win.missed;
					fix_start_q <= seg_start_q;
					fix_end_q   <= seg_start_q + span_q;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (active_rec) begin
				if (row_done) begin
					pos_q       <= '0;
					index_q     <= index_inc[COUNT_W-1:0];
					fix_start_q <= fix_start_q + step_q;
					fix_end_q   <= fix_end_q + step_q;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
				if (cap_start) begin
					held_start_q <= word;
					if (kind_q == KIND_VAR) begin
						held_end_q <= word + span_q;
					end
				end
				if (cap_end) begin
					held_end_q <= word;
				end
			end
			if (bytes.block_last) begin
				in_header_q <= 1'b1;
				pos_q       <= '0;
				asm_q       <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && hdr_done && kind_q == KIND_NONE) begin
			out_valid_q <= 1'b1;
		end else if (accept && row_done && !missed_q && win.hit) begin
			out_valid_q <= 1'b1;
		end else if (rows.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hdr_done && kind_q == KIND_NONE) begin
			out_start_q <= '0;
			out_end_q   <= '0;
			out_value_q <= '0;
			out_chrom_q <= chrom_q;
			out_bad_q   <= 1'b1;
			out_final_q <= 1'b0;
		end else if (accept && row_done && !missed_q && win.hit) begin
			out_start_q <= rs;
			out_end_q   <= re;
			out_value_q <= word;
			out_chrom_q <= chrom_q;
			out_bad_q   <= 1'b0;
			out_final_q <= (index_inc == {1'b0, total_q});
		end
	end

	assign rows.valid          = out_valid_q;
	assign rows.row_start      = out_start_q;
	assign rows.row_end        = out_end_q;
	assign rows.row_value_bits = out_value_q;
	assign rows.chromosome     = out_chrom_q;
	assign rows.bad_type       = out_bad_q;
	assign rows.final_row      = out_final_q;
endmodule
`default_nettype wire

FILE: design/wdbp_checker.sv
// Port-level checks for the wiggle data block parser, bound to its top level.
// Depends on wdbp_pkg and wig_data_block_parser.
`default_nettype none
module wdbp_checker import wdbp_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [WORD_W-1:0] out_start,
	input wire logic [WORD_W-1:0] out_end,
	input wire logic [WORD_W-1:0] out_value,
	input wire logic              out_bad,
	input wire logic              out_final
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_start) && $stable(out_end)
			&& $stable(out_value))
		else $error("pending row changed while stalled");

	a_bad_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_bad |-> out_start == '0 && out_end == '0 && out_value == '0
			&& !out_final)
		else $error("bad type word carries row data");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("row without an accepted byte");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");
endmodule

bind wig_data_block_parser wdbp_checker u_wdbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (bytes.valid),
	.in_ready  (bytes.ready),
	.out_valid (rows.valid),
	.out_ready (rows.ready),
	.out_start (rows.row_start),
	.out_end   (rows.row_end),
	.out_value (rows.row_value_bits),
	.out_bad   (rows.bad_type),
	.out_final (rows.final_row)
);
`default_nettype wire

FILE: bench/wdbp_row_checker.sv
`timescale 1ns / 100ps
// Row checker for the wiggle data block parser: watches the byte, row and register channels,
// predicts every row from the accepted bytes and compares it with the row that comes out.
// Depends on wdbp_pkg and wdbp_if.
module wdbp_row_checker import wdbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	wdbp_byte_if        bytes,
	wdbp_row_if         rows,
	wdbp_cfg_if         cfg,
	output int unsigned mismatches,
	output int unsigned rows_owed
);

	typedef struct packed {
		logic [WORD_W-1:0] start_pos;
		logic [WORD_W-1:0] end_pos;
		logic [WORD_W-1:0] value_bits;
		logic [WORD_W-1:0] chrom;
		logic              bad;
		logic              last_item;
	} row_t;

	row_t rows_due[$];

	logic               swap;
	logic [WORD_W-1:0]  q_begin;
	logic [WORD_W-1:0]  q_end;

	logic [POS_W-1:0]   pos;
	logic               in_hdr;
	logic [WORD_W-1:0]  acc_word;
	logic [WORD_W-1:0]  chrom_id;
	logic [WORD_W-1:0]  seg_s;
	logic [WORD_W-1:0]  seg_e;
	logic [WORD_W-1:0]  step_len;
	logic [WORD_W-1:0]  span_len;
	kind_t              kind;
	logic [COUNT_W-1:0] total;
	logic [COUNT_W-1:0] idx;
	logic [WORD_W-1:0]  held_s;
	logic [WORD_W-1:0]  held_e;
	logic               missed;

	function automatic logic signed [WORD_W-1:0] win_lo();
		return ($signed(q_begin) < 0) ? $signed(seg_s) : $signed(q_begin);
	endfunction

	function automatic logic signed [WORD_W-1:0] win_hi();
		return ($signed(q_end) < 0) ? $signed(seg_e) : $signed(q_end);
	endfunction

	task automatic check_field(input string name, input logic [WORD_W-1:0] want,
		input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_row(input row_t r);
		rows_due.insert(rows_due.size(), r);
	endtask

	task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic last);
		logic [1:0]        lane;
		logic [WORD_W-1:0] w;
		logic              live;
		int                groups;
		int                grp;
		logic [WORD_W-1:0] rs;
		logic [WORD_W-1:0] re;
		row_t              r;
		lane = pos[1:0];
		w = (lane == 2'd0) ? '0 : acc_word;
		live = in_hdr || (kind != KIND_NONE && idx < total);
		if (live) begin
			if (swap)
				w = {w[23:0], b};
			else
				w = w | (WORD_W'(b) << (8 * lane));
			acc_word = w;
		end
		if (in_hdr) begin
			if (pos == HDR_KIND_POS)
				kind = (b >= 8'd1 && b <= 8'd3) ? kind_t'(b[1:0]) : KIND_NONE;
			if (lane == 2'd3) begin
				case (pos[4:2])
					3'd0: chrom_id = w;
					3'd1: seg_s = w;
					3'd2: seg_e = w;
					3'd3: step_len = w;
					3'd4: span_len = w;
					default: total = swap ? w[15:0] : w[31:16];
				endcase
			end
			if (pos >= HDR_LAST_POS) begin
				in_hdr = 1'b0;
				pos = '0;
				idx = '0;
				missed = (win_hi() < $signed(seg_s)) || (win_lo() > $signed(seg_e)) ||
					(win_hi() < win_lo());
				if (kind == KIND_NONE) begin
					r = '{start_pos: '0, end_pos: '0, value_bits: '0, chrom: chrom_id,
						bad: 1'b1, last_item: 1'b0};
					queue_row(r);
				end
			end else begin
				pos = pos + 1'b1;
			end
		end else if (live) begin
			groups = (kind == KIND_BED) ? 3 : (kind == KIND_VAR) ? 2 : 1;
			grp = int'(pos[4:2]);
			if (lane != 2'd3) begin
				pos = pos + 1'b1;
			end else if (grp + 1 < groups) begin
				if (grp == 0)
					held_s = w;
				else
					held_e = w;
				pos = pos + 1'b1;
			end else begin
				case (kind)
					KIND_BED: begin
						rs = held_s;
						re = held_e;
					end
					KIND_VAR: begin
						rs = held_s;
						re = held_s + span_len;
					end
					default: begin
						rs = seg_s + {16'd0, idx} * step_len;
						re = seg_s + span_len + {16'd0, idx} * step_len;
					end
				endcase
				if (!missed && $signed(rs) <= win_hi() && $signed(re) >= win_lo()) begin
					r = '{start_pos: rs, end_pos: re, value_bits: w, chrom: chrom_id,
						bad: 1'b0, last_item: ({1'b0, idx} + 17'd1) == {1'b0, total}};
					queue_row(r);
				end
				idx = idx + 1'b1;
				pos = '0;
			end
		end
		if (last) begin
			in_hdr = 1'b1;
			pos = '0;
			acc_word = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		row_t want;
		if (!arst_n) begin
			rows_due.delete();
			mismatches = 0;
			swap = 1'b0;
			q_begin = '1;
			q_end = '1;
			pos = '0;
			in_hdr = 1'b1;
			acc_word = '0;
			chrom_id = '0;
			seg_s = '0;
			seg_e = '0;
			step_len = '0;
			span_len = '0;
			kind = KIND_NONE;
			total = '0;
			idx = '0;
			held_s = '0;
			held_e = '0;
			missed = 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					CFG_BYTE_SWAPPED: swap = cfg.wdata[0];
					CFG_QUERY_BEGIN:  q_begin = cfg.wdata;
					CFG_QUERY_END:    q_end = cfg.wdata;
					default: ;
				endcase
			end
			if (rows.valid && rows.ready) begin
				if (rows_due.size() == 0) begin
					$error("unexpected row: start %h end %h chromosome %h bad_type %b",
						rows.row_start, rows.row_end, rows.chromosome, rows.bad_type);
					mismatches++;
				end else begin
					want = rows_due.pop_front();
					check_field("row_start", want.start_pos, rows.row_start);
					check_field("row_end", want.end_pos, rows.row_end);
					check_field("row_value_bits", want.value_bits, rows.row_value_bits);
					check_field("chromosome", want.chrom, rows.chromosome);
					check_field("bad_type", WORD_W'(want.bad), WORD_W'(rows.bad_type));
					check_field("final_row", WORD_W'(want.last_item), WORD_W'(rows.final_row));
				end
			end
			if (bytes.valid && bytes.ready)
				parse_byte(bytes.data_byte, bytes.block_last);
		end
		rows_owed = rows_due.size();
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Bench top for the wiggle data block parser: clock, reset, block stimulus and verdict.
// Depends on wdbp_pkg, wdbp_if, wig_data_block_parser and wdbp_row_checker.
module tb_top;
	import wdbp_pkg::*;

	logic            clk;
	logic            arst_n;
	logic            calm;
	logic            swap_now;
	logic [BYTE_W-1:0] blk[$];
	int unsigned     mismatches;
	int unsigned     rows_owed;
	int unsigned     bytes_sent;

	wdbp_byte_if bytes ();
	wdbp_row_if  rows ();
	wdbp_cfg_if  cfg ();

	wig_data_block_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes),
		.rows(rows),
		.cfg(cfg)
	);

	wdbp_row_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes),
		.rows(rows),
		.cfg(cfg),
		.mismatches(mismatches),
		.rows_owed(rows_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		rows.ready = 1'b0;
		forever begin
			@(negedge clk);
			rows.ready = calm || ($urandom_range(99) >= 32);
		end
	end

	task automatic write_reg(input cfg_idx_t a, input logic [WORD_W-1:0] d);
		cfg.valid = 1'b1;
		cfg.addr = a;
		cfg.wdata = d;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// drain the parser before touching the registers
	task automatic apply_window(input logic sw, input logic [WORD_W-1:0] qb,
		input logic [WORD_W-1:0] qe);
		bytes.valid = 1'b0;
		while (rows_owed != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(CFG_BYTE_SWAPPED, WORD_W'(sw));
		write_reg(CFG_QUERY_BEGIN, qb);
		write_reg(CFG_QUERY_END, qe);
		swap_now = sw;
	endtask

	task automatic add_byte(input logic [BYTE_W-1:0] b);
		blk.insert(blk.size(), b);
	endtask

	task automatic push_word(input logic [WORD_W-1:0] w);
		int k;
		for (k = 0; k < 4; k++)
			add_byte(swap_now ? w[31 - 8 * k -: 8] : w[8 * k +: 8]);
	endtask

	task automatic make_block(input logic [WORD_W-1:0] chrom, input logic [WORD_W-1:0] s,
		input logic [WORD_W-1:0] e, input logic [WORD_W-1:0] step,
		input logic [WORD_W-1:0] span, input logic [BYTE_W-1:0] kb,
		input logic [COUNT_W-1:0] count, input int nrec);
		logic [WORD_W-1:0] st;
		int i;
		push_word(chrom);
		push_word(s);
		push_word(e);
		push_word(step);
		push_word(span);
		add_byte(kb);
		add_byte(BYTE_W'($urandom));
		if (swap_now) begin
			add_byte(count[15:8]);
			add_byte(count[7:0]);
		end else begin
			add_byte(count[7:0]);
			add_byte(count[15:8]);
		end
		for (i = 0; i < nrec; i++) begin
			st = ($urandom_range(7) == 0) ? $urandom : s + $urandom_range(3000) - 32'd200;
			if (kb == BYTE_W'(KIND_VAR)) begin
				push_word(st);
			end else if (kb != BYTE_W'(KIND_FIX)) begin
				push_word(st);
				push_word(($urandom_range(9) == 0) ? $urandom : st + $urandom_range(400));
			end
			push_word($urandom);
		end
	endtask

	// hold each byte until taken, with random gaps
	task automatic send_blk();
		int i;
		for (i = 0; i < blk.size(); i++) begin
			while (!calm && $urandom_range(99) < 32) begin
				bytes.valid = 1'b0;
				@(negedge clk);
			end
			bytes.valid = 1'b1;
			bytes.data_byte = blk[i];
			bytes.block_last = (i == blk.size() - 1);
			do @(posedge clk); while (!bytes.ready);
			@(negedge clk);
			bytes_sent++;
		end
		blk.delete();
	endtask

	task automatic random_block();
		logic [WORD_W-1:0]  seg_s;
		logic [WORD_W-1:0]  seg_e;
		logic [WORD_W-1:0]  step;
		logic [WORD_W-1:0]  span;
		logic [BYTE_W-1:0]  kb;
		logic [COUNT_W-1:0] count;
		int roll;
		int nrec;
		roll = $urandom_range(99);
		if (roll < 30)
			kb = BYTE_W'(KIND_BED);
		else if (roll < 55)
			kb = BYTE_W'(KIND_VAR);
		else if (roll < 88)
			kb = BYTE_W'(KIND_FIX);
		else
			kb = $urandom_range(1) ? BYTE_W'(KIND_NONE) : BYTE_W'($urandom_range(4, 255));
		seg_s = ($urandom_range(7) == 0) ? $urandom : $urandom_range(20000);
		step = ($urandom_range(9) == 0) ? $urandom : $urandom_range(600);
		span = ($urandom_range(9) == 0) ? $urandom : $urandom_range(400);
		roll = $urandom_range(31);
		if (roll == 0)
			count = '0;
		else if (roll == 1)
			count = '1;
		else
			count = COUNT_W'($urandom_range(1, 12));
		nrec = (count == '1) ? $urandom_range(6) : int'(count);
		seg_e = ($urandom_range(7) == 0) ? $urandom : seg_s + step * count + span;
		make_block($urandom, seg_s, seg_e, step, span, kb, count, nrec);
		roll = $urandom_range(9);
		if (roll == 0) begin
			repeat ($urandom_range(1, 20)) add_byte(BYTE_W'($urandom));
		end else if (roll == 1) begin
			nrec = $urandom_range(1, blk.size() - 1);
			while (blk.size() > nrec)
				void'(blk.pop_back());
		end
		send_blk();
	endtask

	initial begin
		int ph;
		int unsigned goal;
		logic [WORD_W-1:0] qb;
		bytes.valid = 1'b0;
		bytes.data_byte = '0;
		bytes.block_last = 1'b0;
		cfg.valid = 1'b0;
		cfg.addr = CFG_BYTE_SWAPPED;
		cfg.wdata = '0;
		calm = 1'b0;
		swap_now = 1'b0;
		bytes_sent = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		make_block(32'h0000_0001, 32'd100, 32'd5000, 32'd0, 32'd0, BYTE_W'(KIND_BED),
			16'd2, 2);
		send_blk();
		make_block(32'hFFFF_FFFF, 32'd200, 32'd900, 32'd0, 32'd50, BYTE_W'(KIND_VAR),
			16'd2, 2);
		send_blk();
		make_block(32'd3, 32'd1000, 32'd2000, 32'd100, 32'd25, BYTE_W'(KIND_FIX), 16'd3, 3);
		send_blk();
		make_block(32'd4, 32'h7FFF_FF00, 32'hFFFF_FFFF, 32'h4000_0000, 32'hFFFF_FFFF,
			BYTE_W'(KIND_FIX), 16'd4, 4);
		send_blk();
		make_block(32'd5, 32'd10, 32'd20, 32'd1, 32'd1, BYTE_W'(KIND_NONE), 16'd1, 1);
		send_blk();
		make_block(32'd6, 32'd10, 32'd20, 32'd1, 32'd1, 8'hFF, 16'd1, 0);
		send_blk();
		// zero items, then surplus bytes past the count
		make_block(32'd7, 32'd0, 32'd100, 32'd10, 32'd5, BYTE_W'(KIND_FIX), 16'd0, 2);
		send_blk();
		make_block(32'd8, 32'd0, 32'd100, 32'd10, 32'd5, BYTE_W'(KIND_FIX), 16'd1, 3);
		send_blk();
		// drop partial header, then partial record
		make_block(32'd9, 32'd0, 32'd100, 32'd10, 32'd5, BYTE_W'(KIND_BED), 16'd1, 1);
		while (blk.size() > 10)
			void'(blk.pop_back());
		send_blk();
		make_block(32'd10, 32'd0, 32'd100, 32'd10, 32'd5, BYTE_W'(KIND_BED), 16'd2, 2);
		while (blk.size() > 30)
			void'(blk.pop_back());
		send_blk();
		apply_window(1'b1, 32'd150, 32'd1500);
		make_block(32'd11, 32'd1000, 32'd2000, 32'd100, 32'd25, BYTE_W'(KIND_FIX), 16'd6, 6);
		send_blk();
		make_block(32'd12, 32'd100, 32'd5000, 32'd0, 32'd0, BYTE_W'(KIND_BED), 16'd3, 3);
		send_blk();
		apply_window(1'b0, 32'd6000, 32'd7000);
		make_block(32'd13, 32'd100, 32'd5000, 32'd10, 32'd5, BYTE_W'(KIND_VAR), 16'd2, 2);
		send_blk();

		for (ph = 0; ph < 8; ph++) begin
			qb = $urandom_range(15000);
			case (ph)
				0: apply_window(1'b0, '1, '1);
				1: apply_window(1'b1, '1, '1);
				2: apply_window(1'b0, qb, qb + $urandom_range(10000));
				3: apply_window(1'b1, qb, $urandom_range(20000));
				4: apply_window(1'b0, 32'd0, 32'h7FFF_FFFF);
				5: apply_window(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				6: apply_window(1'b0, '1, qb);
				default: apply_window(1'b1, qb, '1);
			endcase
			calm = (ph == 1);
			goal = bytes_sent + 125;
			while (bytes_sent < goal)
				random_block();
		end
		calm = 1'b0;
		apply_window(1'b0, 32'd0, 32'd0);
		make_block(32'd14, 32'd0, 32'd10, 32'd1, 32'd0, BYTE_W'(KIND_FIX), 16'd3, 3);
		send_blk();

		bytes.valid = 1'b0;
		while (rows_owed != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && rows_owed == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
